// ===== hdl/pje_pkg.sv =====
// shared types and constants of the pose jump extrapolator
// no dependencies; imported by the history cells and the top level
package pje_pkg;

  localparam int COORD_W     = 32;
  localparam int FRAME_W     = 24;
  localparam int THR_W       = 31;
  localparam int SQ_W        = 63;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 160;

  localparam logic [SQ_W-1:0]  SQ_SAT  = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [THR_W-1:0] THR_RST = 31'd2294;

  // one velocity entry of the history
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_EXT,
    ST_COMMIT
  } stage_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXTRAP_EN = 3'd0,
    CFG_JUMP_THR  = 3'd1,
    CFG_ORIGIN_X  = 3'd2,
    CFG_ORIGIN_Y  = 3'd3,
    CFG_ORIGIN_Z  = 3'd4
  } cfg_idx_e;

endpackage

// ===== hdl/pose_jump_extrapolator.sv =====
// pose jump extrapolator top level: stream ports, config registers, sequencer
// depends on pje_pkg, pje_hist_cell and pje_mean_div
//
// usage
//   s_axis carries one camera frame per request: tracked position, frame number
//   and the tracker's converged flag; m_axis returns one corrected pose per frame
//   with the jump flag and the saturated squared speed
//   registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while idle
// timing
//   a request is taken from the input buffer when the sequencer is idle and
//   then passes the datapath steps (velocity, squares, sum, extrapolate, commit);
//   the result is registered at commit and drives m_axis from the output register
//   a frame starts only after the last one commits; this is set by the loop through the
//   corrected position and the history, which the next frame's velocity needs,
//   and by the mean divider that runs during the first stages
//   the input buffer takes the next request while the current one is at work
// reset
//   clears the history cells, running sums, last position and jump flag, and
//   returns the registers to their defaults (disabled, threshold 0.035 m)
// stalls
//   the result waits in the output register; a finished frame holds in commit
//   until that register frees, and the input buffer then fills and drops tready
module pose_jump_extrapolator #(
  parameter int HISTORY_DEPTH = 4,
  parameter int WARMUP_FRAMES = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: meas_x, meas_y, meas_z, frame_index
  input  logic [pje_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: track_ok
  input  logic                               s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: out_x, out_y, out_z, speed_sq, zero pad
  output logic [pje_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser: jump_flag
  output logic                               m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_we_i,
  input  logic [pje_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pje_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import pje_pkg::*;

  localparam int SUM_W = COORD_W + $clog2(HISTORY_DEPTH);
  localparam int EXT_W = 36;
  localparam logic [FRAME_W-1:0] WarmLim = FRAME_W'(WARMUP_FRAMES);
  localparam logic [FRAME_W-1:0] HistLim = FRAME_W'(HISTORY_DEPTH);

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [EXT_W-1:0] v);
    if (v > 36'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < 36'shF_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[COORD_W-1:0];
  endfunction

  // configuration
  logic                      en_q;
  logic [THR_W-1:0]          thr_q;
  logic signed [COORD_W-1:0] org_q [3];

  // input buffer
  logic                      in_full_q;
  logic signed [COORD_W-1:0] in_m_q [3];
  logic                      in_ok_q;
  logic [FRAME_W-1:0]        in_frame_q;

  // frame state
  logic signed [COORD_W-1:0] last_rel_q [3];
  logic                      prev_jump_q;
  logic signed [SUM_W-1:0]   sum_q [3];

  // sequencer
  stage_e state_q, state_d;
  logic   start, fire, out_free;

  // datapath stages
  logic signed [COORD_W-1:0] meas_q [3];
  logic                      ok_q, warm_q, hist_on_q, hist_wr_q;
  logic signed [EXT_W-1:0]   v_q [3];
  logic signed [EXT_W-1:0]   prev_q [3];
  logic signed [COORD_W-1:0] relm_q [3];
  logic [63:0]               prod_q [3];
  logic                      big_q [3];
  logic signed [COORD_W-1:0] hvm_q [3];
  logic [61:0]               thr2_q;
  logic [SQ_W-1:0]           ssq_q;
  logic                      gt_q;
  logic signed [COORD_W-1:0] ext_q [3];
  logic signed [COORD_W-1:0] px_q [3];

  // divider results
  logic [SUM_W-1:0]          quo [3];
  logic                      neg [3];

  // commit values
  logic                      jump;
  logic signed [COORD_W-1:0] ox [3];
  logic signed [COORD_W-1:0] rel [3];
  logic signed [COORD_W-1:0] hw [3];
  vel_t                      hw_vel;
  vel_t                      chain [HISTORY_DEPTH+1];

  // output register
  logic                      out_valid_q;
  logic [OUT_TDATA_W-1:0]    out_data_q;
  logic                      out_user_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      thr_q <= THR_RST;
      for (int c = 0; c < 3; c++) begin
        org_q[c] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXTRAP_EN: en_q     <= cfg_wdata_i[0];
        CFG_JUMP_THR:  thr_q    <= cfg_wdata_i[THR_W-1:0];
        CFG_ORIGIN_X:  org_q[0] <= cfg_wdata_i;
        CFG_ORIGIN_Y:  org_q[1] <= cfg_wdata_i;
        CFG_ORIGIN_Z:  org_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input buffer
  // one request deep; refills in the same cycle the datapath takes it
  assign s_axis_tready = !in_full_q || start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full_q <= 1'b1;
    end else if (start) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_m_q[0]  <= s_axis_tdata[31:0];
      in_m_q[1]  <= s_axis_tdata[63:32];
      in_m_q[2]  <= s_axis_tdata[95:64];
      in_frame_q <= s_axis_tdata[119:96];
      in_ok_q    <= s_axis_tuser;
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    start   = 1'b0;
    fire    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_full_q) begin
          start   = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_EXT;
      ST_EXT:  state_d = ST_COMMIT;
      ST_COMMIT: begin
        // hold the finished frame until the output register can take it
        if (out_free) begin
          fire    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    // velocity against the last corrected position, previous absolute position
    if (start) begin
      ok_q      <= in_ok_q;
      warm_q    <= in_frame_q >= WarmLim;
      hist_on_q <= in_frame_q > HistLim;
      hist_wr_q <= (in_frame_q > HistLim) && (in_frame_q > WarmLim);
      for (int c = 0; c < 3; c++) begin
        meas_q[c] <= in_m_q[c];
        v_q[c]    <= EXT_W'(in_m_q[c]) - EXT_W'(org_q[c]) - EXT_W'(last_rel_q[c]);
        prev_q[c] <= EXT_W'(last_rel_q[c]) + EXT_W'(org_q[c]);
        relm_q[c] <= sat32(EXT_W'(in_m_q[c]) - EXT_W'(org_q[c]));
      end
    end
    // squares; a magnitude of 2^32 or more saturates outright
    if (state_q == ST_MUL) begin
      for (int c = 0; c < 3; c++) begin
        logic signed [32:0] vs;
        logic signed [65:0] p;
        vs = v_q[c][32:0];
        p  = vs * vs;
        prod_q[c] <= p[63:0];
        big_q[c]  <= (v_q[c] > 36'sh0_FFFF_FFFF) || (v_q[c] < 36'shF_0000_0001);
        hvm_q[c]  <= sat32(v_q[c]);
      end
      thr2_q <= thr_q * thr_q;
    end
    // saturating sum of the three squares, taken in one add
    if (state_q == ST_ADD) begin
      logic [SQ_W-1:0] sqc [3];
      logic [SQ_W+1:0] tot;
      for (int c = 0; c < 3; c++) begin
        sqc[c] = (big_q[c] || prod_q[c][63]) ? SQ_SAT : prod_q[c][SQ_W-1:0];
      end
      tot = (SQ_W+2)'(sqc[0]) + (SQ_W+2)'(sqc[1]) + (SQ_W+2)'(sqc[2]);
      ssq_q <= (tot[SQ_W+1:SQ_W] != 2'b00) ? SQ_SAT : tot[SQ_W-1:0];
    end
    // threshold compare and extrapolated position from the history mean
    if (state_q == ST_EXT) begin
      logic signed [33:0] mag;
      logic signed [33:0] pxs;
      gt_q <= ssq_q > SQ_W'(thr2_q);
      for (int c = 0; c < 3; c++) begin
        mag = {2'b00, quo[c][COORD_W-1:0]};
        pxs = !hist_on_q ? 34'sd0 : (neg[c] ? -mag : mag);
        ext_q[c] <= sat32(prev_q[c] + EXT_W'(pxs));
        px_q[c]  <= pxs[COORD_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- mean dividers
  for (genvar g = 0; g < 3; g++) begin : g_div
    pje_mean_div #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SUM_W         (SUM_W)
    ) u_div (
      .clk_i   (clk_i),
      .start_i (start),
      .sum_i   (sum_q[g]),
      .quo_o   (quo[g]),
      .neg_o   (neg[g])
    );
  end

  // ---------------------------------------------------------------- commit
  // jump needs a large step or a lost track, once warmed up and enabled, not right after another jump
  assign jump = (gt_q || !ok_q) && !prev_jump_q && warm_q && en_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ox[c]  = jump ? ext_q[c] : meas_q[c];
      rel[c] = jump ? sat32(EXT_W'(ext_q[c]) - EXT_W'(org_q[c])) : relm_q[c];
      hw[c]  = !hist_wr_q ? 32'sd0 : (jump ? px_q[c] : hvm_q[c]);
    end
    hw_vel.x = hw[0];
    hw_vel.y = hw[1];
    hw_vel.z = hw[2];
  end

  // history as a shift line: the entry dropped at the far end is the oldest
  assign chain[0] = hw_vel;
  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    pje_hist_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (fire),
      .vel_i   (chain[g]),
      .vel_o   (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_jump_q <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        last_rel_q[c] <= '0;
        sum_q[c]      <= '0;
      end
    end else if (fire) begin
      prev_jump_q <= jump;
      last_rel_q  <= rel;
      // running sums follow the shift line: add the new entry, drop the oldest
      sum_q[0] <= sum_q[0] + SUM_W'(hw[0]) - SUM_W'(chain[HISTORY_DEPTH].x);
      sum_q[1] <= sum_q[1] + SUM_W'(hw[1]) - SUM_W'(chain[HISTORY_DEPTH].y);
      sum_q[2] <= sum_q[2] + SUM_W'(hw[2]) - SUM_W'(chain[HISTORY_DEPTH].z);
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {1'b0, ssq_q, ox[2], ox[1], ox[0]};
      out_user_q <= jump;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== hdl/pje_hist_cell.sv =====
// one cell of the velocity history shift line
// depends on pje_pkg for the velocity entry type
module pje_hist_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         shift_i,
  input  pje_pkg::vel_t vel_i,
  output pje_pkg::vel_t vel_o
);
  import pje_pkg::*;

  vel_t vel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '0;
    end else if (shift_i) begin
      vel_q <= vel_i;
    end
  end

  assign vel_o = vel_q;

endmodule

// ===== hdl/pje_mean_div.sv =====
// divides a signed history sum by the history depth, truncating toward zero
// hex digit serial with a constant remainder table; no dependencies
module pje_mean_div #(
  parameter int HISTORY_DEPTH = 4,
  parameter int SUM_W         = 34
) (
  input  logic                    clk_i,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output logic        [SUM_W-1:0] quo_o,
  output logic                    neg_o
);

  localparam int NDIG   = (SUM_W + 3) / 4;
  localparam int DPC    = (NDIG + 2) / 3;
  localparam int STEP_W = DPC * 4;
  localparam int NW     = STEP_W * 3;

  typedef logic [7:0] div_tbl_t [256];

  // entry {remainder, digit} -> {quotient digit, new remainder}
  function automatic div_tbl_t build_div_tbl();
    div_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = {4'(i / HISTORY_DEPTH), 4'(i % HISTORY_DEPTH)};
    end
    return t;
  endfunction

  localparam div_tbl_t DivTbl = build_div_tbl();

  logic [NW-1:0]     num_q, num_d;
  logic [NW-1:0]     quo_q, quo_d;
  logic [3:0]        rem_q, rem_d;
  logic              neg_q;

  always_comb begin
    logic [SUM_W-1:0]  mag;
    logic [NW-1:0]     num;
    logic [3:0]        r;
    logic [STEP_W-1:0] qd;
    logic [7:0]        e;
    mag = sum_i[SUM_W-1] ? $unsigned(-sum_i) : $unsigned(sum_i);
    num = start_i ? NW'(mag) : num_q;
    r   = start_i ? 4'd0 : rem_q;
    qd  = '0;
    for (int k = 0; k < DPC; k++) begin
      e = DivTbl[{r, num[NW-1-4*k -: 4]}];
      qd[STEP_W-1-4*k -: 4] = e[7:4];
      r = e[3:0];
    end
    num_d = num << STEP_W;
    quo_d = {quo_q[NW-STEP_W-1:0], qd};
    rem_d = r;
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      neg_q <= sum_i[SUM_W-1];
    end
  end

  assign quo_o = quo_q[SUM_W-1:0];
  assign neg_o = neg_q;

endmodule
